>>> rtl/klc_pkg.sv
// Shared types and constants of the keyed line cache.
// Depends on nothing; klc_ctrl, klc_datapath and the top level use it by scoped names.
`timescale 1ns / 1ps

package klc_pkg;

  localparam int SLOT_W = 7;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_INVAL  = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        window_id;
    logic signed [15:0] row_number;
    logic [7:0]         piece_number;
    logic [31:0]        payload;
    logic               any_row;
    logic               any_piece;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_payload;
    slot_t       slot;
  } rsp_t;

  // One table entry as it sits in the RAM.
  typedef struct packed {
    logic               valid;
    logic [15:0]        window_id;
    logic signed [15:0] row_number;
    logic [7:0]         piece_number;
    logic [31:0]        payload;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic write;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic stop;
    logic is_store;
    logic out_free;
  } ctrl_status_t;

endpackage

>>> rtl/klc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps

module klc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/klc_ctrl.sv
// Sequencer of the keyed line cache: clearing pass, scan, write back, result hand-off.
// Depends on klc_pkg for the command and status types.
`timescale 1ns / 1ps

module klc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  klc_pkg::ctrl_status_t status,
  output klc_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_WRITE  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.stop) begin
          state_next = status.is_store ? ST_WRITE : ST_FINISH;
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/klc_datapath.sv
// Datapath of the keyed line cache: entry RAM, scan compare, replace pointer, response register.
// Depends on klc_pkg and klc_ram.
`timescale 1ns / 1ps

module klc_datapath #(
  parameter int ENTRIES = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  klc_pkg::req_t         req,
  input  klc_pkg::ctrl_cmd_t    cmd,
  output klc_pkg::ctrl_status_t status,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output klc_pkg::rsp_t         rsp
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  klc_pkg::req_t   cur;
  klc_pkg::entry_t rd_data;
  klc_pkg::entry_t wr_data;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;
  logic            rd_en;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] rd_addr;
  logic          iss_active;
  logic          cmp_valid;
  logic [AW-1:0] cmp_addr;

  logic          found;
  logic [AW-1:0] found_idx;
  logic [31:0]   found_pay;
  logic          free;
  logic [AW-1:0] free_idx;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] target;
  logic [AW-1:0] wr_slot;

  logic key_hit;
  logic inval_hit;
  logic is_lookup;
  logic is_store;
  logic is_inval;

  assign is_lookup = (cur.operation == klc_pkg::OP_LOOKUP);
  assign is_store  = (cur.operation == klc_pkg::OP_STORE);
  assign is_inval  = (cur.operation == klc_pkg::OP_INVAL);

  assign key_hit = rd_data.valid && (rd_data.window_id == cur.window_id) &&
                   (rd_data.row_number == cur.row_number) &&
                   (rd_data.piece_number == cur.piece_number);

  assign inval_hit = rd_data.valid && (rd_data.window_id == cur.window_id) &&
                     (cur.any_row || (rd_data.row_number == cur.row_number)) &&
                     (cur.any_piece || (rd_data.piece_number == cur.piece_number));

  assign ptr_inc = (ptr == LAST) ? '0 : ptr + AW'(1);

  always_comb begin
    if (found) begin
      target = found_idx;
    end else if (free) begin
      target = free_idx;
    end else begin
      target = ptr_inc;
    end
  end

  // Write port: clearing pass, store write back, or clearing a matched entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_addr;
    wr_data = '0;
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
    end else if (cmd.write) begin
      wr_en                = 1'b1;
      wr_addr              = target;
      wr_data.valid        = 1'b1;
      wr_data.window_id    = cur.window_id;
      wr_data.row_number   = cur.row_number;
      wr_data.piece_number = cur.piece_number;
      wr_data.payload      = cur.payload;
    end else if (cmd.scan && cmp_valid && is_inval && inval_hit) begin
      wr_en = 1'b1;
    end
  end

  assign rd_en = cmd.scan && iss_active;

  klc_ram #(
    .WIDTH ($bits(klc_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign status.clear_last = (clr_addr == LAST);
  assign status.stop       = cmp_valid &&
                             ((cmp_addr == LAST) || (key_hit && (is_lookup || is_store)));
  assign status.is_store   = is_store;
  assign status.out_free   = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      iss_active <= 1'b0;
      cmp_valid  <= 1'b0;
      found      <= 1'b0;
      free       <= 1'b0;
      ptr        <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + AW'(1);
      end

      if (cmd.load) begin
        cur        <= req;
        rd_addr    <= '0;
        iss_active <= 1'b1;
        cmp_valid  <= 1'b0;
        found      <= 1'b0;
        free       <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= iss_active;
        cmp_addr  <= rd_addr;
        if (iss_active) begin
          rd_addr <= rd_addr + AW'(1);
          if (rd_addr == LAST) begin
            iss_active <= 1'b0;
          end
        end
        if (cmp_valid) begin
          if (key_hit && !found) begin
            found     <= 1'b1;
            found_idx <= cmp_addr;
            found_pay <= rd_data.payload;
          end
          if (!rd_data.valid && !free) begin
            free     <= 1'b1;
            free_idx <= cmp_addr;
          end
        end
      end else begin
        cmp_valid <= 1'b0;
      end

      if (cmd.write) begin
        wr_slot <= target;
        if (!found && !free) begin
          ptr <= ptr_inc;
        end
      end

      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload has no reset; it is only loaded on hand-off.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.hit           <= is_lookup && found;
      rsp.found_payload <= (is_lookup && found) ? found_pay : '0;
      if (is_lookup && found) begin
        rsp.slot <= klc_pkg::slot_t'(found_idx);
      end else if (is_store) begin
        rsp.slot <= klc_pkg::slot_t'(wr_slot);
      end else begin
        rsp.slot <= '0;
      end
    end
  end

endmodule

>>> rtl/keyed_line_cache_round_robin_unit.sv
// Top level of the keyed line cache with round-robin replacement.
// Depends on klc_pkg, klc_ctrl and klc_datapath (which holds the klc_ram instance).
`timescale 1ns / 1ps

// Channel   Signals                 Direction  Contents
// request   req_valid/req_stall/req in         operation, key, payload, wildcards
// response  rsp_valid/rsp_stall/rsp out        hit, found_payload, slot
//
// The RAM's single read port gives a scan of one entry per cycle. A lookup or a store
// stops at the first entry with its key; a miss, an invalidate or the unused code scans
// all ENTRIES entries, and a store then writes back before its response is registered.
// Reset starts a clearing pass that writes every entry invalid with req_stall high.
// A finished response waits in its own register, so the next request is taken and
// scanned while rsp_stall holds it back.

module keyed_line_cache_round_robin_unit #(
  parameter int ENTRIES = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  klc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output klc_pkg::rsp_t rsp
);

  // Commands flow from the sequencer to the datapath; status flows back.
  klc_pkg::ctrl_cmd_t    cmd;
  klc_pkg::ctrl_status_t status;

  klc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath captures the request on its transfer, scans the table and holds
  // the replace pointer, which advances before use and wraps at ENTRIES.
  klc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
